// ===== sv/bbr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbr_pkg
// Shared types, constants and helpers of the 3x3 RGB box blur.
// ----------------------------------------------------------------------------
package bbr_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 2048;
    localparam int MIN_SIZE       = 3;
    localparam int WIN_SIZE       = 3;

    localparam int FW_W       = 11;
    localparam int FH_W       = 12;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 12;

    localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 11'd640;
    localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 12'd480;

    // x / 9 == (x * 1821) >> 14 for every window sum up to 9 * 255
    localparam int               DIV9_MUL_W = 11;
    localparam logic [10:0]      DIV9_MUL   = 11'd1821;
    localparam int               DIV9_SHIFT = 14;

    localparam int COL_SUM_W = 10;
    localparam int WIN_SUM_W = 12;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } pixel_t;

    typedef struct packed {
        pixel_t top;
        pixel_t mid;
        pixel_t bot;
    } column_t;

    typedef struct packed {
        pixel_t upper;
        pixel_t lower;
    } line_pair_t;

    typedef struct packed {
        logic [COL_SUM_W-1:0] r;
        logic [COL_SUM_W-1:0] g;
        logic [COL_SUM_W-1:0] b;
    } colsum_t;

    typedef struct packed {
        logic [WIN_SUM_W-1:0] r;
        logic [WIN_SUM_W-1:0] g;
        logic [WIN_SUM_W-1:0] b;
    } winsum_t;

    function automatic colsum_t col_sum(input column_t c);
        colsum_t s;
        s.r = COL_SUM_W'(c.top.r) + COL_SUM_W'(c.mid.r) + COL_SUM_W'(c.bot.r);
        s.g = COL_SUM_W'(c.top.g) + COL_SUM_W'(c.mid.g) + COL_SUM_W'(c.bot.g);
        s.b = COL_SUM_W'(c.top.b) + COL_SUM_W'(c.mid.b) + COL_SUM_W'(c.bot.b);
        return s;
    endfunction

    function automatic logic [7:0] div9(input logic [WIN_SUM_W-1:0] s);
        logic [WIN_SUM_W+DIV9_MUL_W-1:0] prod;
        prod = (WIN_SUM_W+DIV9_MUL_W)'(s) * (WIN_SUM_W+DIV9_MUL_W)'(DIV9_MUL);
        return prod[DIV9_SHIFT+7:DIV9_SHIFT];
    endfunction

endpackage

// ===== sv/bbr_line_buf.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbr_line_buf
// Two line stores kept side by side in one memory, registered read.
// ----------------------------------------------------------------------------
module bbr_line_buf #(
    parameter int DEPTH = bbr_pkg::MAX_WIDTH_DEF
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  bbr_pkg::line_pair_t      wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output bbr_pkg::line_pair_t      rd_data
);
    import bbr_pkg::*;

    line_pair_t mem [0:DEPTH-1];
    line_pair_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/bbr_win_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbr_win_cell
// One window column: holds three pixels and their per-channel sum,
// hands the pixels to the next cell on every shift and offers the sum to the window sum.
// ----------------------------------------------------------------------------
module bbr_win_cell (
    input  logic             clk,
    input  logic             shift_en,
    input  bbr_pkg::column_t col_in,
    output bbr_pkg::column_t col_out,
    output bbr_pkg::colsum_t sum_out
);
    import bbr_pkg::*;

    column_t col_reg;
    column_t col_next;
    colsum_t sum_reg;
    colsum_t sum_next;

    always_comb
    begin
        col_next = col_reg;
        sum_next = sum_reg;
        if (shift_en)
        begin
            col_next = col_in;
            sum_next = col_sum(col_in);
        end
    end

    always_ff @(posedge clk)
    begin
        col_reg <= col_next;
        sum_reg <= sum_next;
    end

    assign col_out = col_reg;
    assign sum_out = sum_reg;

endmodule

// ===== sv/box_blur_3x3_rgb_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_blur_3x3_rgb_unit
// 3x3 mean blur over an RGB raster stream; border pixels pass through.
// ----------------------------------------------------------------------------
// channel  dir  handshake           payload
// s_*      in   s_tvalid/s_tready   tdata: red, green, blue; tuser: is_flush
// m_*      out  m_tvalid/m_tready   tdata: red, green, blue; tlast: frame_end
// cfg_*    in   cfg_we              index 0 frame_width, 1 frame_height
//
// one word per cycle sustained unless the output stalls: one line store read
// and one write per cycle. a result passes the sum stage, then is divided
// into the output register, from which it is offered.
// results trail inputs by one row plus one pixel; frame_width+1 flush words
// drain a frame. reset clears counters and valids; stores need no clearing.
// s_tready drops only while both stages are full and m_tready is low.
// ----------------------------------------------------------------------------
module box_blur_3x3_rgb_unit #(
    parameter int MAX_WIDTH  = bbr_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = bbr_pkg::MAX_HEIGHT_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [23:0]                    s_tdata,   // red [7:0], green [15:8], blue [23:16]
    input  logic                           s_tuser,   // is_flush
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [23:0]                    m_tdata,   // red [7:0], green [15:8], blue [23:16]
    output logic                           m_tlast,   // frame_end
    input  logic                           cfg_we,
    input  logic [bbr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bbr_pkg::CFG_DATA_W-1:0] cfg_data
);
    import bbr_pkg::*;

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);
    localparam int RW    = $clog2(MAX_HEIGHT + 2);
    localparam int NCELL = WIN_SIZE - 1;

    // configuration and position
    logic [FW_W-1:0] fw_reg, fw_next;
    logic [FH_W-1:0] fh_reg, fh_next;
    logic [CW-1:0]   col_reg, col_next;
    logic [RW-1:0]   row_reg, row_next;
    logic [WW-1:0]   w_eff;
    logic [HW-1:0]   h_eff;

    // step control
    logic accept, advance, is_tail, is_last, has_result, interior;
    logic out_free;

    pixel_t     in_pix;
    line_pair_t lb_rd;
    line_pair_t lb_wr;
    column_t    cell_col [0:NCELL-1];
    colsum_t    cell_sum [0:NCELL-1];
    colsum_t    new_sum;
    winsum_t    win_sum;

    // sum stage
    logic    s1_valid_reg, s1_valid_next;
    logic    s1_interior_reg, s1_interior_next;
    logic    s1_last_reg, s1_last_next;
    winsum_t s1_sum_reg, s1_sum_next;

    // output register
    logic    out_valid_reg, out_valid_next;
    logic    out_last_reg, out_last_next;
    pixel_t  out_pix_reg, out_pix_next;

    always_comb
    begin
        if (fw_reg < FW_W'(MIN_SIZE))
            w_eff = WW'(MIN_SIZE);
        else if (32'(fw_reg) > MAX_WIDTH)
            w_eff = WW'(MAX_WIDTH);
        else
            w_eff = WW'(fw_reg);

        if (fh_reg < FH_W'(MIN_SIZE))
            h_eff = HW'(MIN_SIZE);
        else if (32'(fh_reg) > MAX_HEIGHT)
            h_eff = HW'(MAX_HEIGHT);
        else
            h_eff = HW'(fh_reg);
    end

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = !s1_valid_reg || out_free;
    assign accept   = s_tvalid && s_tready;

    assign is_tail    = 32'(row_reg) >= 32'(h_eff);
    assign is_last    = 32'(row_reg) >= 32'(h_eff) + 1;
    // a flush word inside the frame is dropped without effect
    assign advance    = accept && (is_tail || !s_tuser);
    assign has_result = (row_reg >= RW'(2)) || (row_reg == RW'(1) && col_reg != '0);
    assign interior   = (col_reg >= CW'(2)) && (row_reg >= RW'(2)) && !is_tail;

    // pixels in the drain row are zeros
    always_comb
    begin
        in_pix.r = is_tail ? 8'd0 : s_tdata[7:0];
        in_pix.g = is_tail ? 8'd0 : s_tdata[15:8];
        in_pix.b = is_tail ? 8'd0 : s_tdata[23:16];
    end

    always_comb
    begin
        fw_next  = fw_reg;
        fh_next  = fh_reg;
        col_next = col_reg;
        row_next = row_reg;
        if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_FRAME_WIDTH:  fw_next = cfg_data[FW_W-1:0];
                REG_FRAME_HEIGHT: fh_next = cfg_data[FH_W-1:0];
                default:          fw_next = fw_reg;
            endcase
            col_next = '0;
            row_next = '0;
        end
        else if (advance)
        begin
            if (is_last)
            begin
                col_next = '0;
                row_next = '0;
            end
            else if (32'(col_reg) + 1 >= 32'(w_eff))
            begin
                col_next = '0;
                row_next = row_reg + RW'(1);
            end
            else
            begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_reg  <= FRAME_WIDTH_RST;
            fh_reg  <= FRAME_HEIGHT_RST;
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            fw_reg  <= fw_next;
            fh_reg  <= fh_next;
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // read ahead at the next column so the stored pair is ready with the word
    assign lb_wr.upper = lb_rd.lower;
    assign lb_wr.lower = in_pix;

    bbr_line_buf #(
        .DEPTH (MAX_WIDTH)
    ) u_line_buf (
        .clk     (clk),
        .wr_en   (advance),
        .wr_addr (col_reg),
        .wr_data (lb_wr),
        .rd_addr (col_next),
        .rd_data (lb_rd)
    );

    assign cell_col[0] = '{top: lb_rd.upper, mid: lb_rd.lower, bot: in_pix};

    generate
        for (genvar i = 0; i < NCELL; i++)
        begin : g_cell
            if (i < NCELL - 1)
            begin : g_mid
                bbr_win_cell u_cell (
                    .clk      (clk),
                    .shift_en (advance),
                    .col_in   (cell_col[i]),
                    .col_out  (cell_col[i+1]),
                    .sum_out  (cell_sum[i])
                );
            end
            else
            begin : g_end
                bbr_win_cell u_cell (
                    .clk      (clk),
                    .shift_en (advance),
                    .col_in   (cell_col[i]),
                    .col_out  (),
                    .sum_out  (cell_sum[i])
                );
            end
        end
    endgenerate

    always_comb
    begin
        new_sum   = col_sum(cell_col[0]);
        win_sum.r = WIN_SUM_W'(new_sum.r);
        win_sum.g = WIN_SUM_W'(new_sum.g);
        win_sum.b = WIN_SUM_W'(new_sum.b);
        for (int i = 0; i < NCELL; i++)
        begin
            win_sum.r = win_sum.r + WIN_SUM_W'(cell_sum[i].r);
            win_sum.g = win_sum.g + WIN_SUM_W'(cell_sum[i].g);
            win_sum.b = win_sum.b + WIN_SUM_W'(cell_sum[i].b);
        end
    end

    // sum stage: window sum for interior pixels, else the center pixel
    always_comb
    begin
        s1_valid_next    = s1_valid_reg && !out_free;
        s1_interior_next = s1_interior_reg;
        s1_last_next     = s1_last_reg;
        s1_sum_next      = s1_sum_reg;
        if (advance && has_result)
        begin
            s1_valid_next    = 1'b1;
            s1_interior_next = interior;
            s1_last_next     = is_last;
            if (interior)
            begin
                s1_sum_next = win_sum;
            end
            else
            begin
                s1_sum_next.r = WIN_SUM_W'(cell_col[1].mid.r);
                s1_sum_next.g = WIN_SUM_W'(cell_col[1].mid.g);
                s1_sum_next.b = WIN_SUM_W'(cell_col[1].mid.b);
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !m_tready;
        out_last_next  = out_last_reg;
        out_pix_next   = out_pix_reg;
        if (s1_valid_reg && out_free)
        begin
            out_valid_next = 1'b1;
            out_last_next  = s1_last_reg;
            out_pix_next.r = s1_interior_reg ? div9(s1_sum_reg.r) : s1_sum_reg.r[7:0];
            out_pix_next.g = s1_interior_reg ? div9(s1_sum_reg.g) : s1_sum_reg.g[7:0];
            out_pix_next.b = s1_interior_reg ? div9(s1_sum_reg.b) : s1_sum_reg.b[7:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_interior_reg <= s1_interior_next;
        s1_last_reg     <= s1_last_next;
        s1_sum_reg      <= s1_sum_next;
        out_last_reg    <= out_last_next;
        out_pix_reg     <= out_pix_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_pix_reg.b, out_pix_reg.g, out_pix_reg.r};
    assign m_tlast  = out_last_reg;

    // position stays inside the frame plus its drain row
    a_col_range : assert property (@(posedge clk) disable iff (!rst_n)
        32'(col_reg) < 32'(w_eff))
        else $error("column counter outside the frame width");

    a_row_range : assert property (@(posedge clk) disable iff (!rst_n)
        32'(row_reg) <= 32'(h_eff) + 1)
        else $error("row counter beyond the drain row");

    a_frame_wrap : assert property (@(posedge clk) disable iff (!rst_n)
        (advance && is_last && !cfg_we) |=> (col_reg == '0 && row_reg == '0))
        else $error("position not back at frame start after last result");

    a_stage_hold : assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !out_free) |=> (s1_valid_reg && $stable(s1_sum_reg)))
        else $error("sum stage lost or changed a word under stall");

endmodule
